@@ design/tcw_pkg.sv @@
// Package for the text console writer: screen geometry, field widths,
// request and state codes, and the structs passed between modules.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int COL_W      = $clog2(COLUMNS);

    localparam int CUR_W      = 11;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int NIBBLE_W   = 4;
    localparam int CELL_DW    = CHAR_W + COLOR_W;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [NIBBLE_W-1:0] FG_RESET = 4'd2;
    localparam logic [NIBBLE_W-1:0] BG_RESET = 4'd0;

    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_BACK = 2'd1,
        REQ_READ = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic put;
        logic newline;
        logic back;
    } t_cur_cmd;

    typedef struct packed {
        logic [CELL_W-1:0] index;
        logic [CELL_W-1:0] next;
        logic              wrap;
    } t_cur_stat;

    typedef struct packed {
        logic [CUR_W-1:0]   cursor;
        logic               update;
        logic [CHAR_W-1:0]  chr;
        logic [COLOR_W-1:0] color;
        logic               scrolled;
    } t_result;

endpackage

`default_nettype wire

@@ design/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/tcw_cursor.sv @@
// Cursor tracker: keeps row, column and cell index, steps them per command
// and flags the wrap past the last row. Depends on tcw_pkg.
`default_nettype none

module tcw_cursor (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tcw_pkg::t_cur_cmd  i_cmd,
    output tcw_pkg::t_cur_stat      o_stat
);
    import tcw_pkg::*;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CELL_W-1:0] r_idx, n_idx;
    logic              last_col, last_row, step_row, wrap;

    always_comb begin
        last_col = (r_col == COL_W'(COLUMNS - 1));
        last_row = (r_row == ROW_W'(ROWS - 1));
        step_row = i_cmd.newline || (i_cmd.put && last_col);
        wrap     = 1'b0;
        n_row    = r_row;
        n_col    = r_col;
        n_idx    = r_idx;
        if (step_row) begin
            n_col = '0;
            if (last_row) begin
                wrap  = 1'b1;
                n_row = ROW_W'(ROWS - 1);
                n_idx = CELL_W'(MOVE_COUNT);
            end else begin
                n_row = r_row + ROW_W'(1);
                n_idx = r_idx + CELL_W'(COLUMNS) - CELL_W'(r_col);
            end
        end else if (i_cmd.put) begin
            n_col = r_col + COL_W'(1);
            n_idx = r_idx + CELL_W'(1);
        end else if (i_cmd.back && (r_idx != '0)) begin
            n_idx = r_idx - CELL_W'(1);
            if (r_col == '0) begin
                n_col = COL_W'(COLUMNS - 1);
                n_row = r_row - ROW_W'(1);
            end else begin
                n_col = r_col - COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_idx <= n_idx;
        end
    end

    assign o_stat.index = r_idx;
    assign o_stat.next  = n_idx;
    assign o_stat.wrap  = wrap;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_idx) < CELL_COUNT)
        else $error("cursor index out of range");

    a_idx_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_idx) == 32'(r_row) * COLUMNS + 32'(r_col))
        else $error("cursor index disagrees with row and column");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor row or column out of range");

endmodule

`default_nettype wire

@@ design/text_console_writer.sv @@
// Text console writer top level: request FSM, screen RAM, cursor tracker,
// result and output registers. Depends on tcw_pkg, tcw_ram, tcw_cursor.
//
//  channel  dir  handshake            payload
//  s        in   tvalid/tready        tdata: char_code, cell_index; tuser: req_type;
//                                     tlast: end_of_text
//  m        out  tvalid/tready        tdata: cursor_position, cell_char, cell_color;
//                                     tuser: cursor_update, scrolled
//  cfg      in   we                   index 0 foreground_color, 1 background_color
//
// Put without scroll, cursor back and unused requests pass through PUSH; reads go
// through READ first (registered RAM read). A put that scrolls walks every cell in
// SCROLL: one RAM read and one write per cell through the single write port.
// After reset a clearing pass writes zero to every cell with no beat accepted;
// config writes are taken throughout.
// A stalled m side holds the result in the output register; the next beat is
// accepted meanwhile and its result waits until the register frees.
`default_nettype none

module text_console_writer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [tcw_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                     i_s_tuser,
    input  wire logic                           i_s_tlast,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [10:0] cursor_position, [18:11] cell_char, [26:19] cell_color, [31:27] zero
    output logic      [tcw_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [0] cursor_update, [1] scrolled
    output logic      [1:0]                     o_m_tuser,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [tcw_pkg::NIBBLE_W-1:0]   i_cfg_data
);
    import tcw_pkg::*;

    t_state             r_state, n_state;
    logic [CELL_W-1:0]  r_pos, n_pos;
    logic [NIBBLE_W-1:0] r_fg, r_bg;
    logic               r_wv;
    logic [CELL_W-1:0]  r_dst;
    logic               r_blank;
    logic               r_rd_ok;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               accept, slot_free, push;
    t_req               req;
    logic [CHAR_W-1:0]  in_char;
    logic [CUR_W-1:0]   in_index;
    logic [COLOR_W-1:0] color;
    t_cur_cmd           cur_cmd;
    t_cur_stat          cur_stat;

    logic               ram_we;
    logic [CELL_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_DW-1:0] ram_wdata, ram_rdata;

    assign req        = t_req'(i_s_tuser);
    assign in_char    = i_s_tdata[CHAR_W-1:0];
    assign in_index   = i_s_tdata[CHAR_W+CUR_W-1:CHAR_W];
    assign color      = {r_bg, r_fg};
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign push       = (r_state == ST_PUSH) && slot_free;

    always_comb begin
        cur_cmd.put     = accept && (req == REQ_PUT) && (in_char != NEWLINE_CODE);
        cur_cmd.newline = accept && (req == REQ_PUT) && (in_char == NEWLINE_CODE);
        cur_cmd.back    = accept && (req == REQ_BACK);
    end

    tcw_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cur_cmd),
        .o_stat  (cur_stat)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_stat.index;
        ram_wdata = {color, in_char};
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_pos;
            ram_wdata = '0;
        end else if (r_wv) begin
            ram_we    = 1'b1;
            ram_waddr = r_dst;
            ram_wdata = {color, r_blank ? BLANK_CODE : ram_rdata[CHAR_W-1:0]};
        end else if (cur_cmd.put) begin
            ram_we = 1'b1;
        end
        if (r_state == ST_SCROLL) begin
            ram_raddr = CELL_W'(32'(r_pos) + COLUMNS);
        end else begin
            ram_raddr = CELL_W'(in_index);
        end
    end

    tcw_ram #(
        .WIDTH (CELL_DW),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        case (r_state)
            ST_CLEAR: begin
                n_pos = r_pos + CELL_W'(1);
                if (r_pos == CELL_W'(CELL_COUNT - 1)) begin
                    n_pos   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if ((req == REQ_PUT) && cur_stat.wrap) begin
                        n_pos   = '0;
                        n_state = ST_SCROLL;
                    end else if (req == REQ_READ) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_PUSH;
            end
            ST_SCROLL: begin
                n_pos = r_pos + CELL_W'(1);
                if (r_pos == CELL_W'(CELL_COUNT - 1)) begin
                    n_pos   = '0;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_fg        <= FG_RESET;
            r_bg        <= BG_RESET;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_wv    <= (r_state == ST_SCROLL);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FG) begin
                    r_fg <= i_cfg_data;
                end else begin
                    r_bg <= i_cfg_data;
                end
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst   <= r_pos;
        r_blank <= (32'(r_pos) >= MOVE_COUNT);
        if (accept) begin
            r_rd_ok         <= (32'(in_index) < CELL_COUNT);
            r_res.cursor    <= CUR_W'(cur_stat.next);
            r_res.chr       <= '0;
            r_res.color     <= '0;
            r_res.scrolled  <= (req == REQ_PUT) && cur_stat.wrap;
            case (req)
                REQ_PUT:  r_res.update <= i_s_tlast;
                REQ_BACK: r_res.update <= (cur_stat.index != '0);
                default:  r_res.update <= 1'b0;
            endcase
        end
        if ((r_state == ST_READ) && r_rd_ok) begin
            r_res.chr   <= ram_rdata[CHAR_W-1:0];
            r_res.color <= ram_rdata[CELL_DW-1:CHAR_W];
        end
        if (push) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - CUR_W - CHAR_W - COLOR_W)'(0),
                         r_out.color, r_out.chr, r_out.cursor};
    assign o_m_tuser  = {r_out.scrolled, r_out.update};

    a_wb_after_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> $past(r_state == ST_SCROLL))
        else $error("scroll write-back without a scroll read");

    a_scroll_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("scroll read and write hit the same cell");

    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH && r_out_valid && !i_m_tready) |=> (r_state == ST_PUSH))
        else $error("result left before output register freed");

    a_no_put_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> !accept)
        else $error("beat accepted during scroll write-back");

endmodule

`default_nettype wire
